// ===== rtl/core/pid_sep_pkg.sv =====
package pid_sep_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 16;
  localparam int LIMIT_W     = 15;
  localparam int BOUND_W     = 23;
  localparam int ACC_W       = 24;
  localparam int DRIVE_W     = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 23;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(150);
  localparam logic [BOUND_W-1:0] BOUND_RESET = BOUND_W'(1200);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KP        = 3'd0,
    REG_KI        = 3'd1,
    REG_KD        = 3'd2,
    REG_SEP_LIMIT = 3'd3,
    REG_INT_BOUND = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] target_value;
    logic signed [SAMPLE_W-1:0] measured_value;
  } sample_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_value;
    logic                      integrating;
  } result_t;

endpackage

// ===== rtl/core/pid_integral_separation_unit.sv =====
// Positional PID step with integral separation and a clamped integral. Each
// sample beat (target, measurement) yields one result beat: the drive, formed
// from Q(GAIN_FRAC_BITS) gains and the integral state left by the previous
// sample, and a flag telling whether this sample was added to the integral.
// The unit takes one sample per clock while the result side does not stall.
// The accepted sample moves through three registers in order: the error,
// integral and separation update finish in the input stage, the three gain
// multiplies fill the second stage and the sum, shift and 32-bit saturation
// fill the output register. Stall on the result side backs up through the
// three stages before it reaches sample_stall.
// Write gains and limits only while no sample is in flight.
module pid_integral_separation_unit #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  pid_sep_pkg::sample_t                   sample,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output pid_sep_pkg::result_t                   result,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pid_sep_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pid_sep_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pid_sep_pkg::*;

  localparam int ERR_W  = SAMPLE_W + 1;
  localparam int DIFF_W = SAMPLE_W + 2;
  localparam int ASUM_W = ((ERR_W > ACC_W) ? ERR_W : ACC_W) + 1;
  localparam int CMP_W  = ((SAMPLE_W > LIMIT_W) ? SAMPLE_W : LIMIT_W) + 2;
  localparam int P_W    = GAIN_W + 1 + ERR_W;
  localparam int D_W    = GAIN_W + 1 + DIFF_W;
  localparam int I_W    = GAIN_W + 1 + ACC_W;
  localparam int PD_W   = (P_W > D_W) ? P_W : D_W;
  localparam int SUM_W  = ((PD_W > I_W) ? PD_W : I_W) + 2;

  // configuration
  logic [GAIN_W-1:0]  kp;
  logic [GAIN_W-1:0]  ki;
  logic [GAIN_W-1:0]  kd;
  logic [LIMIT_W-1:0] separation_limit;
  logic [BOUND_W-1:0] integral_bound;

  // controller state
  logic signed [ACC_W-1:0] accumulated_error;
  logic signed [ERR_W-1:0] last_error;
  logic                    integrate_enable;

  // stage 1
  logic                    s1_valid;
  logic signed [ERR_W-1:0]  s1_error;
  logic signed [DIFF_W-1:0] s1_diff;
  logic signed [ACC_W-1:0]  s1_acc;
  logic                    s1_integrating;

  // stage 2
  logic                  s2_valid;
  logic signed [P_W-1:0] s2_p;
  logic signed [D_W-1:0] s2_d;
  logic signed [I_W-1:0] s2_i;
  logic                  s2_integrating;

  logic out_ready;
  logic s2_ready;
  logic s1_ready;
  logic accept;

  logic signed [ERR_W-1:0]  error;
  logic signed [DIFF_W-1:0] diff;
  logic signed [CMP_W-1:0]  meas_ext;
  logic signed [CMP_W-1:0]  lim_ext;
  logic                     outside;
  logic signed [ASUM_W-1:0] acc_sum;
  logic signed [ASUM_W-1:0] bound_ext;
  logic signed [ASUM_W-1:0] acc_clamped;
  logic signed [ACC_W-1:0]  accumulated_error_next;

  logic signed [SUM_W-1:0]   pid_sum;
  logic signed [SUM_W-1:0]   pid_shifted;
  logic signed [DRIVE_W-1:0] drive_next;

  assign cfg_ready    = 1'b1;
  assign out_ready    = !result_valid || !result_stall;
  assign s2_ready     = !s2_valid || out_ready;
  assign s1_ready     = !s1_valid || s2_ready;
  assign sample_stall = !s1_ready;
  assign accept       = sample_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp               <= '0;
      ki               <= '0;
      kd               <= '0;
      separation_limit <= LIMIT_RESET;
      integral_bound   <= BOUND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KP:        kp               <= cfg_data[GAIN_W-1:0];
        REG_KI:        ki               <= cfg_data[GAIN_W-1:0];
        REG_KD:        kd               <= cfg_data[GAIN_W-1:0];
        REG_SEP_LIMIT: separation_limit <= cfg_data[LIMIT_W-1:0];
        REG_INT_BOUND: integral_bound   <= cfg_data[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // error, separation test and clamped integral for the incoming beat
  always_comb begin
    error    = ERR_W'(sample.target_value) - ERR_W'(sample.measured_value);
    diff     = DIFF_W'(error) - DIFF_W'(last_error);
    meas_ext = CMP_W'(sample.measured_value);
    lim_ext  = $signed(CMP_W'(separation_limit));
    outside  = (meas_ext > lim_ext) || (meas_ext < -lim_ext);

    acc_sum   = ASUM_W'(accumulated_error) + ASUM_W'(error);
    bound_ext = $signed(ASUM_W'(integral_bound));
    if (acc_sum > bound_ext) begin
      acc_clamped = bound_ext;
    end else if (acc_sum < -bound_ext) begin
      acc_clamped = -bound_ext;
    end else begin
      acc_clamped = acc_sum;
    end
    accumulated_error_next = ACC_W'(acc_clamped);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulated_error <= '0;
      last_error        <= '0;
      integrate_enable  <= 1'b0;
      s1_valid          <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= sample_valid;
      end
      if (accept) begin
        last_error       <= error;
        integrate_enable <= !outside;
        if (!outside) begin
          accumulated_error <= accumulated_error_next;
        end
      end
    end
  end

  // drive uses the flag and integral left by the previous beat
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_error       <= error;
      s1_diff        <= diff;
      s1_acc         <= integrate_enable ? accumulated_error : '0;
      s1_integrating <= !outside;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_p           <= $signed({1'b0, kp}) * s1_error;
      s2_d           <= $signed({1'b0, kd}) * s1_diff;
      s2_i           <= $signed({1'b0, ki}) * s1_acc;
      s2_integrating <= s1_integrating;
    end
  end

  // sum, floor shift, saturate
  always_comb begin
    pid_sum     = SUM_W'(s2_p) + SUM_W'(s2_d) + SUM_W'(s2_i);
    pid_shifted = pid_sum >>> GAIN_FRAC_BITS;
    if (!pid_shifted[SUM_W-1] && (|pid_shifted[SUM_W-2:DRIVE_W-1])) begin
      drive_next = {1'b0, {(DRIVE_W-1){1'b1}}};
    end else if (pid_shifted[SUM_W-1] && !(&pid_shifted[SUM_W-2:DRIVE_W-1])) begin
      drive_next = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive_next = pid_shifted[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_valid) begin
      result.drive_value <= drive_next;
      result.integrating <= s2_integrating;
    end
  end

  a_acc_within_bound: assert property (@(posedge clk) disable iff (rst)
    (accept && !outside) |=>
      (accumulated_error <= $signed(ACC_W'(integral_bound)) &&
       accumulated_error >= -$signed(ACC_W'(integral_bound))))
    else $error("integral left outside its bound");

  a_flag_tracks_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> (s1_valid && s1_integrating == integrate_enable))
    else $error("stage flag and integrate flag disagree");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (s1_valid && s2_valid && result_valid && result_stall))
    else $error("sample stalled with room in the pipeline");

endmodule
